FILE: src/lpfd_pkg.sv
// Shared types and constants of the length-prefixed frame decoder.
package lpfd_pkg;

  // Header sizes in bytes: the base header and the header of a file-backed message.
  localparam int unsigned HdrBaseLen = 10;
  localparam int unsigned HdrFileLen = 12;

  // Width of the header byte counter and of the header store index.
  localparam int unsigned HdrCntW = 4;

  localparam logic [7:0] VersionOne = 8'h01;
  localparam logic [7:0] TagInline  = 8'h00;
  localparam logic [7:0] TagFile    = 8'h01;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_PAYLOAD,
    PH_PATH
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_PATH,
    KIND_ERROR
  } kind_e;

  typedef enum logic {
    MSG_INLINE,
    MSG_FILE
  } msg_e;

  typedef enum logic [1:0] {
    ERR_VERSION,
    ERR_ZERO_LEN,
    ERR_TAG,
    ERR_ZERO_PATH
  } err_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    msg_e        msg_kind;
    logic [63:0] msg_len;
    logic [15:0] path_size;
    logic [7:0]  data;
    logic        last;
    err_e        err;
  } result_t;

endpackage

FILE: src/lpfd_core.sv
// Decoder state and per-byte next-state and result logic.
module lpfd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output lpfd_pkg::result_t res_o
);

  lpfd_pkg::phase_e              phase_q, phase_d;
  logic [lpfd_pkg::HdrCntW-1:0]  cnt_q, cnt_d;
  logic [63:0]                   rem_q, rem_d;
  logic [15:0]                   path_rem_q, path_rem_d;
  logic [7:0]                    store_q [lpfd_pkg::HdrFileLen];

  logic [lpfd_pkg::HdrCntW-1:0]  idx;
  logic [lpfd_pkg::HdrCntW-1:0]  cnt_inc;
  logic [7:0]                    hv [lpfd_pkg::HdrFileLen];
  logic [63:0]                   hdr_len;
  logic [63:0]                   store_len;
  logic [15:0]                   hdr_path;
  logic [15:0]                   store_path;
  logic                          rem_last;
  logic                          path_last;
  logic                          wr_en;

  // The header view holds the incoming byte at its slot, so the checks see the whole header.
  always_comb begin
    idx = (cnt_q >= lpfd_pkg::HdrCntW'(lpfd_pkg::HdrFileLen)) ? '0 : cnt_q;
    cnt_inc = idx + lpfd_pkg::HdrCntW'(1);
    for (int i = 0; i < lpfd_pkg::HdrFileLen; i++) begin
      hv[i] = (lpfd_pkg::HdrCntW'(i) == idx) ? byte_i : store_q[i];
    end
    for (int i = 0; i < 8; i++) begin
      hdr_len[8*i +: 8]   = hv[i+2];
      store_len[8*i +: 8] = store_q[i+2];
    end
    hdr_path   = {hv[11], hv[10]};
    store_path = {store_q[11], store_q[10]};
    rem_last   = (rem_q[63:1] == '0);
    path_last  = (path_rem_q[15:1] == '0);
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    path_rem_d = path_rem_q;
    wr_en      = 1'b0;
    res_o      = '0;

    unique case (phase_q)
      lpfd_pkg::PH_PAYLOAD: begin
        res_o.valid    = 1'b1;
        res_o.kind     = lpfd_pkg::KIND_PAYLOAD;
        res_o.msg_kind = lpfd_pkg::MSG_INLINE;
        res_o.msg_len  = store_len;
        res_o.data     = byte_i;
        res_o.last     = rem_last;
        rem_d          = rem_last ? '0 : rem_q - 64'd1;
        if (rem_last) begin
          phase_d = lpfd_pkg::PH_HEAD;
        end
      end
      lpfd_pkg::PH_PATH: begin
        res_o.valid     = 1'b1;
        res_o.kind      = lpfd_pkg::KIND_PATH;
        res_o.msg_kind  = lpfd_pkg::MSG_FILE;
        res_o.msg_len   = store_len;
        res_o.path_size = store_path;
        res_o.data      = byte_i;
        res_o.last      = path_last;
        path_rem_d      = path_last ? '0 : path_rem_q - 16'd1;
        if (path_last) begin
          phase_d = lpfd_pkg::PH_HEAD;
        end
      end
      default: begin
        // Header gathering; the spare phase code behaves the same way.
        phase_d = lpfd_pkg::PH_HEAD;
        wr_en   = 1'b1;
        cnt_d   = cnt_inc;
        if (cnt_inc == lpfd_pkg::HdrCntW'(lpfd_pkg::HdrBaseLen)) begin
          if (hv[0] != lpfd_pkg::VersionOne) begin
            cnt_d       = '0;
            res_o.valid = 1'b1;
            res_o.kind  = lpfd_pkg::KIND_ERROR;
            res_o.err   = lpfd_pkg::ERR_VERSION;
          end else if (hdr_len == '0) begin
            cnt_d       = '0;
            res_o.valid = 1'b1;
            res_o.kind  = lpfd_pkg::KIND_ERROR;
            res_o.err   = lpfd_pkg::ERR_ZERO_LEN;
          end else if (hv[1] == lpfd_pkg::TagInline) begin
            cnt_d          = '0;
            rem_d          = hdr_len;
            phase_d        = lpfd_pkg::PH_PAYLOAD;
            res_o.valid    = 1'b1;
            res_o.kind     = lpfd_pkg::KIND_HEADER;
            res_o.msg_kind = lpfd_pkg::MSG_INLINE;
            res_o.msg_len  = hdr_len;
          end else if (hv[1] != lpfd_pkg::TagFile) begin
            cnt_d       = '0;
            res_o.valid = 1'b1;
            res_o.kind  = lpfd_pkg::KIND_ERROR;
            res_o.err   = lpfd_pkg::ERR_TAG;
          end
        end else if (cnt_inc == lpfd_pkg::HdrCntW'(lpfd_pkg::HdrFileLen)) begin
          cnt_d = '0;
          if (hdr_path == '0) begin
            res_o.valid = 1'b1;
            res_o.kind  = lpfd_pkg::KIND_ERROR;
            res_o.err   = lpfd_pkg::ERR_ZERO_PATH;
          end else begin
            path_rem_d      = hdr_path;
            phase_d         = lpfd_pkg::PH_PATH;
            res_o.valid     = 1'b1;
            res_o.kind      = lpfd_pkg::KIND_HEADER;
            res_o.msg_kind  = lpfd_pkg::MSG_FILE;
            res_o.msg_len   = hdr_len;
            res_o.path_size = hdr_path;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lpfd_pkg::PH_HEAD;
      cnt_q      <= '0;
      rem_q      <= '0;
      path_rem_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      path_rem_q <= path_rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      store_q[idx] <= byte_i;
    end
  end

endmodule

FILE: src/length_prefixed_frame_decoder_top.sv
// Top level of the length-prefixed frame decoder: input register, decoder core, result register.
// Flow: an accepted byte waits in the input register until the result register has room;
// the core then decodes it and any result it produces is registered for the master side.
// Throughput: one byte per cycle while results are taken; a stalled result holds the input
// register, and with it the slave side, until taken.
// Reset: asynchronous, active low; clears phase, counters and valid flags, not the header store.
module length_prefixed_frame_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [63:0] message_length, [79:64] path_length,
                                        // [87:80] data_byte, [89:88] error_code, rest zero
  output logic [2:0]  m_axis_tuser_o,   // [1:0] result_kind, [2] message_kind
  output logic        m_axis_tlast_o    // last_flag
);

  // Input register: holds one accepted byte until the decoder consumes it.
  logic              s1_valid_q, s1_valid_d;
  logic [7:0]        s1_byte_q;

  // Result register: one result waiting for the downstream side.
  logic              out_valid_q, out_valid_d;
  lpfd_pkg::result_t out_q;
  lpfd_pkg::result_t res;

  logic              s_accept;
  logic              out_free;
  logic              advance;

  // The decoder steps whenever a byte is waiting and the result register can take
  // whatever that byte produces, either because it is empty or drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  lpfd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, 2'(out_q.err), out_q.data, out_q.path_size, out_q.msg_len};
  assign m_axis_tuser_o  = {1'(out_q.msg_kind), 2'(out_q.kind)};
  assign m_axis_tlast_o  = out_q.last;

`ifndef SYNTHESIS
  // Only payload and path bytes can close a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tuser_o[1:0] == lpfd_pkg::KIND_PAYLOAD ||
       m_axis_tuser_o[1:0] == lpfd_pkg::KIND_PATH))
    else $error("last flag on a result that is neither payload nor path");

  // An error result carries its code and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1:0] == lpfd_pkg::KIND_ERROR) |->
      (m_axis_tdata_o[87:0] == '0 && !m_axis_tuser_o[2] && !m_axis_tlast_o))
    else $error("error result with nonzero header or data fields");

  // Results other than errors report no error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1:0] != lpfd_pkg::KIND_ERROR) |->
      (m_axis_tdata_o[89:88] == '0))
    else $error("error code set on a non-error result");

  // A byte that cannot step because the result register is blocked stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_byte_q)))
    else $error("pending input byte lost while the result side stalled");
`endif

endmodule

FILE: dv/length_prefixed_frame_decoder_top_tb.sv
// Self-checking testbench of the length-prefixed frame decoder: directed and random byte streams.
module length_prefixed_frame_decoder_top_tb;

  // Longest stretch without any accepted request before the run is declared hung.
  localparam int unsigned WatchdogCycles = 2000;
  // Length of the receiver hold-off that fills the decoder and stalls its input.
  localparam int unsigned LongHoldCycles = 80;

  typedef struct {
    lpfd_pkg::kind_e kind;
    lpfd_pkg::msg_e  msg_kind;
    logic [63:0]     msg_len;
    logic [15:0]     path_size;
    logic [7:0]      data;
    logic            last;
    lpfd_pkg::err_e  err;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Decoder state as the predictor sees it.
  lpfd_pkg::phase_e dec_phase = lpfd_pkg::PH_HEAD;
  int unsigned      hdr_cnt = 0;
  logic [7:0]       hdr_bytes [lpfd_pkg::HdrFileLen];
  logic [63:0]      payload_left = '0;
  logic [15:0]      path_left = '0;

  frame_result_t pending_results[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   bytes_sent = 0;
  bit            src_gaps = 1'b0;
  bit            sink_gaps = 1'b0;
  bit            hold_req = 1'b0;

  length_prefixed_frame_decoder_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Length field of the current header, little endian in bytes 2 to 9.
  function automatic logic [63:0] stored_len();
    return {hdr_bytes[9], hdr_bytes[8], hdr_bytes[7], hdr_bytes[6],
            hdr_bytes[5], hdr_bytes[4], hdr_bytes[3], hdr_bytes[2]};
  endfunction

  function automatic frame_result_t make_result(lpfd_pkg::kind_e kind, lpfd_pkg::msg_e mk,
                                                logic [63:0] len, logic [15:0] pl,
                                                logic [7:0] data, logic last,
                                                lpfd_pkg::err_e err);
    frame_result_t r;
    r.kind      = kind;
    r.msg_kind  = mk;
    r.msg_len   = len;
    r.path_size = pl;
    r.data      = data;
    r.last      = last;
    r.err       = err;
    return r;
  endfunction

  // A header fault reports only its code and sends the decoder back to header hunting.
  task automatic header_fault(input lpfd_pkg::err_e code);
    dec_phase = lpfd_pkg::PH_HEAD;
    hdr_cnt   = 0;
    pending_results.push_back(make_result(lpfd_pkg::KIND_ERROR, lpfd_pkg::MSG_INLINE, '0, '0,
                                          '0, 1'b0, code));
  endtask

  // Advances the predicted decoder by one accepted byte and queues the result it causes.
  task automatic decode_byte(input logic [7:0] b);
    logic        is_last;
    logic [15:0] pl;
    if (dec_phase == lpfd_pkg::PH_PAYLOAD) begin
      is_last      = (payload_left <= 64'd1);
      payload_left = is_last ? '0 : payload_left - 64'd1;
      if (is_last) dec_phase = lpfd_pkg::PH_HEAD;
      pending_results.push_back(make_result(lpfd_pkg::KIND_PAYLOAD, lpfd_pkg::MSG_INLINE,
                                            stored_len(), '0, b, is_last,
                                            lpfd_pkg::ERR_VERSION));
      return;
    end
    if (dec_phase == lpfd_pkg::PH_PATH) begin
      is_last   = (path_left <= 16'd1);
      path_left = is_last ? '0 : path_left - 16'd1;
      if (is_last) dec_phase = lpfd_pkg::PH_HEAD;
      pending_results.push_back(make_result(lpfd_pkg::KIND_PATH, lpfd_pkg::MSG_FILE,
                                            stored_len(), {hdr_bytes[11], hdr_bytes[10]}, b,
                                            is_last, lpfd_pkg::ERR_VERSION));
      return;
    end
    dec_phase = lpfd_pkg::PH_HEAD;
    if (hdr_cnt >= lpfd_pkg::HdrFileLen) hdr_cnt = 0;
    hdr_bytes[lpfd_pkg::HdrCntW'(hdr_cnt)] = b;
    hdr_cnt++;
    if (hdr_cnt < lpfd_pkg::HdrBaseLen) return;
    if (hdr_cnt == lpfd_pkg::HdrBaseLen) begin
      // The version is checked first, then the length, then the tag.
      if (hdr_bytes[0] != lpfd_pkg::VersionOne) begin
        header_fault(lpfd_pkg::ERR_VERSION);
      end else if (stored_len() == '0) begin
        header_fault(lpfd_pkg::ERR_ZERO_LEN);
      end else if (hdr_bytes[1] == lpfd_pkg::TagInline) begin
        payload_left = stored_len();
        dec_phase    = lpfd_pkg::PH_PAYLOAD;
        hdr_cnt      = 0;
        pending_results.push_back(make_result(lpfd_pkg::KIND_HEADER, lpfd_pkg::MSG_INLINE,
                                              stored_len(), '0, '0, 1'b0,
                                              lpfd_pkg::ERR_VERSION));
      end else if (hdr_bytes[1] != lpfd_pkg::TagFile) begin
        header_fault(lpfd_pkg::ERR_TAG);
      end
      return;
    end
    if (hdr_cnt < lpfd_pkg::HdrFileLen) return;
    pl = {hdr_bytes[11], hdr_bytes[10]};
    if (pl == '0) begin
      header_fault(lpfd_pkg::ERR_ZERO_PATH);
    end else begin
      path_left = pl;
      dec_phase = lpfd_pkg::PH_PATH;
      hdr_cnt   = 0;
      pending_results.push_back(make_result(lpfd_pkg::KIND_HEADER, lpfd_pkg::MSG_FILE,
                                            stored_len(), pl, '0, 1'b0,
                                            lpfd_pkg::ERR_VERSION));
    end
  endtask

  // Offers one byte, waits for the decoder to take it and predicts its effect.
  task automatic send_byte(input logic [7:0] b);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] ver, input logic [7:0] tag,
                             input logic [63:0] len);
    send_byte(ver);
    send_byte(tag);
    for (int i = 0; i < 8; i++) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_path_len(input logic [15:0] pl);
    send_byte(pl[7:0]);
    send_byte(pl[15:8]);
  endtask

  // Body bytes are random, with the extremes showing up now and then.
  task automatic send_body(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_byte(8'h00);
      else if (pick == 1) send_byte(8'hFF);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_inline_extremes();
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagInline, 64'd1);
    send_byte(8'h00);
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagInline, 64'd3);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
  endtask

  // A file-backed message may carry any nonzero length, so the widest one is used here.
  task automatic test_file_backed();
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagFile, 64'hFFFF_FFFF_FFFF_FFFF);
    send_path_len(16'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagFile, 64'h8000_0000_0000_0001);
    send_path_len(16'd1);
    send_byte(8'h81);
  endtask

  task automatic test_header_faults();
    // A bad version wins over a zero length.
    send_header(8'h00, lpfd_pkg::TagInline, 64'd0);
    send_header(8'hFF, lpfd_pkg::TagInline, 64'd4);
    // A file-backed header with a zero length fails before its path length is read.
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagFile, 64'd0);
    send_header(lpfd_pkg::VersionOne, 8'h02, 64'd7);
    send_header(lpfd_pkg::VersionOne, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagFile, 64'd5);
    send_path_len(16'd0);
    // The decoder must have resynchronized after the faults.
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagInline, 64'd1);
    send_byte(8'h3C);
  endtask

  // Mostly well-formed frames with random content, the rest broken headers.
  task automatic test_random_frames(input int unsigned n_bytes, input bit with_gaps);
    int unsigned stop_at;
    int unsigned pick;
    logic [63:0] len;
    logic [15:0] pl;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      src_gaps  = with_gaps && ($urandom_range(0, 3) != 0);
      sink_gaps = with_gaps && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        len = 64'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6));
        send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagInline, len);
        send_body(32'(len));
      end else if (pick < 16) begin
        len = {$urandom, $urandom};
        if (len == '0) len = 64'd1;
        pl = 16'(($urandom_range(0, 15) == 0) ? $urandom_range(200, 300)
                                              : $urandom_range(1, 6));
        send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagFile, len);
        send_path_len(pl);
        send_body(32'(pl));
      end else if (pick == 16) begin
        send_header(8'($urandom_range(2, 256)), 8'($urandom_range(0, 255)),
                    {$urandom, $urandom});
      end else if (pick == 17) begin
        send_header(lpfd_pkg::VersionOne, 8'($urandom_range(0, 1)), 64'd0);
      end else if (pick == 18) begin
        send_header(lpfd_pkg::VersionOne, 8'($urandom_range(2, 255)),
                    {$urandom, $urandom} | 64'd1);
      end else begin
        send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagFile, {$urandom, $urandom} | 64'd1);
        send_path_len(16'd0);
      end
    end
  endtask

  // The receiver holds off while a long frame streams in, so the input side must stall.
  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_req  = 1'b1;
    send_header(lpfd_pkg::VersionOne, lpfd_pkg::TagInline, 64'd48);
    send_body(48);
  endtask

  // Receiver: random stall bursts, plus the long hold-off when one is requested.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHoldCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] act);
    if (want !== act) begin
      $display("%0t: %s expected %h, actual %h", $time, what, want, act);
      mismatch_cnt++;
    end
  endtask

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    frame_result_t r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: no result expected, actual tuser %h tdata %h", $time, m_axis_tuser_o,
                 m_axis_tdata_o);
        mismatch_cnt++;
      end else begin
        r = pending_results.pop_front();
        check_field("result_kind", 64'(r.kind), 64'(m_axis_tuser_o[1:0]));
        check_field("message_kind", 64'(r.msg_kind), 64'(m_axis_tuser_o[2]));
        check_field("message_length", r.msg_len, m_axis_tdata_o[63:0]);
        check_field("path_length", 64'(r.path_size), 64'(m_axis_tdata_o[79:64]));
        check_field("data_byte", 64'(r.data), 64'(m_axis_tdata_o[87:80]));
        check_field("error_code", 64'(r.err), 64'(m_axis_tdata_o[89:88]));
        check_field("tdata padding", '0, 64'(m_axis_tdata_o[95:90]));
        check_field("last_flag", 64'(r.last), 64'(m_axis_tlast_o));
      end
    end
  end

  // Watchdog: ends the run once no request has moved on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogCycles) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("length_prefixed_frame_decoder_top: mismatch");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    test_inline_extremes();
    test_file_backed();
    test_header_faults();
    test_random_frames(270, 1'b1);
    test_backpressure();
    // Last part of the run goes at full rate on both sides.
    test_random_frames(100, 1'b0);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("length_prefixed_frame_decoder_top: match");
    end else begin
      $display("length_prefixed_frame_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
